// ----- src/qdrpm_pkg.sv -----
// shared types and constants for the quadrature decoder and rpm meter
`default_nettype none

package qdrpm_pkg;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_PHASE_A = 2'd1,
    KIND_PHASE_B = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 2'd1;

  localparam logic [15:0] CPR_RESET      = 16'd4096;
  localparam logic [15:0] INTERVAL_RESET = 16'd100;
  localparam logic [15:0] MS_PER_MINUTE  = 16'd60000;
  localparam logic [15:0] RPM_MAX        = 16'hFFFF;
  localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

  localparam int POS_W = 32;
  localparam int MAG_W = 32;
  localparam int NUM_W = MAG_W + 16;
  localparam int DEN_W = 32;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic                    sample;
    logic [MAG_W-1:0]        mag;
    logic [15:0]             elapsed;
  } entry_t;

endpackage

`default_nettype wire

// ----- src/qdrpm_front.sv -----
// front end: decodes items, keeps the edge count and the millisecond counter
`default_nettype none

module qdrpm_front
  import qdrpm_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire logic [1:0]  kind,
  input  wire logic        level_a,
  input  wire logic        level_b,
  input  wire logic [15:0] sample_interval_ms,
  output entry_t           entry
);

  localparam logic signed [COUNT_WIDTH-1:0] LIM = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] NEG_LIM =
    {1'b1, {(COUNT_WIDTH-2){1'b0}}, 1'b1};

  logic signed [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [15:0]                   elapsed_r, elapsed_nxt;
  logic [15:0]                   elapsed_inc;
  logic                          up;
  logic                          sample;
  logic [COUNT_WIDTH-1:0]        mag;

  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 16'd1;
  assign mag = count_r[COUNT_WIDTH-1] ? COUNT_WIDTH'(-count_r) : COUNT_WIDTH'(count_r);

  always_comb begin
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    sample      = 1'b0;
    up          = 1'b0;
    unique case (kind_t'(kind))
      KIND_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc >= sample_interval_ms) begin
          sample      = 1'b1;
          count_nxt   = '0;
          elapsed_nxt = '0;
        end
      end
      KIND_PHASE_A, KIND_PHASE_B: begin
        // a change on b counts opposite to a change on a
        up = (kind_t'(kind) == KIND_PHASE_A) ? (level_a != level_b) : (level_a == level_b);
        if (up) begin
          if (count_r != LIM) count_nxt = count_r + COUNT_WIDTH'(1);
        end else begin
          if (count_r != NEG_LIM) count_nxt = count_r - COUNT_WIDTH'(1);
        end
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_comb begin
    entry.pos     = POS_W'(count_nxt);
    entry.sample  = sample;
    entry.mag     = MAG_W'(mag);
    entry.elapsed = elapsed_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      elapsed_r <= '0;
    end else if (push) begin
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/qdrpm_fifo.sv -----
// short queue of decoded items between front and back
`default_nettype none

module qdrpm_fifo
  import qdrpm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t wr_entry,
  input  wire logic   pop,
  output entry_t      rd_entry,
  output logic        full,
  output logic        empty
);

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     fill_r, fill_nxt;

  assign full     = (fill_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (fill_r == '0);
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/qdrpm_back.sv -----
// back end: rpm division sequencer and result register
`default_nettype none

module qdrpm_back
  import qdrpm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               empty,
  input  wire entry_t             head,
  output logic                    pop,
  input  wire logic [15:0]        counts_per_rev,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [POS_W-1:0] out_position_count,
  output logic [15:0]             out_speed_rpm,
  output logic                    out_sample_taken
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_CHK  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic [15:0]             el_r, el_nxt;
  logic [NUM_W-1:0]        num_r, num_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt;
  logic [NUM_W-1:0]        rem_r, rem_nxt;
  logic [15:0]             quo_r, quo_nxt;
  logic [3:0]              bit_r, bit_nxt;
  logic [15:0]             rpm_r, rpm_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [15:0]             out_rpm_r, out_rpm_nxt;
  logic                    out_sample_r, out_sample_nxt;
  logic                    out_free;
  logic [15:0]             cpr_eff;
  logic [NUM_W-1:0]        den_sh;

  assign out_free = !out_valid_r || !out_stall;
  assign cpr_eff  = (counts_per_rev == 16'd0) ? 16'd1 : counts_per_rev;
  assign den_sh   = NUM_W'(den_r) << bit_r;

  always_comb begin
    state_nxt      = state_r;
    mag_nxt        = mag_r;
    el_nxt         = el_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    bit_nxt        = bit_r;
    rpm_nxt        = rpm_r;
    out_pos_nxt    = out_pos_r;
    out_rpm_nxt    = out_rpm_r;
    out_sample_nxt = out_sample_r;
    out_valid_nxt  = out_valid_r && out_stall;
    pop            = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!empty && out_free) begin
          pop = 1'b1;
          if (head.sample) begin
            mag_nxt   = head.mag;
            el_nxt    = head.elapsed;
            state_nxt = S_MUL;
          end else begin
            out_valid_nxt  = 1'b1;
            out_pos_nxt    = head.pos;
            out_rpm_nxt    = rpm_r;
            out_sample_nxt = 1'b0;
          end
        end
      end
      S_MUL: begin
        num_nxt   = NUM_W'(mag_r) * NUM_W'(MS_PER_MINUTE);
        den_nxt   = DEN_W'(cpr_eff) * DEN_W'(el_r);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // quotient of 2^16 or more saturates
        if (num_r >= {den_r, 16'h0000}) begin
          quo_nxt   = RPM_MAX;
          state_nxt = S_OUT;
        end else begin
          rem_nxt   = num_r;
          quo_nxt   = '0;
          bit_nxt   = 4'd15;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_r >= den_sh) begin
          rem_nxt        = rem_r - den_sh;
          quo_nxt[bit_r] = 1'b1;
        end
        if (bit_r == 4'd0) state_nxt = S_OUT;
        else bit_nxt = bit_r - 4'd1;
      end
      S_OUT: begin
        if (out_free) begin
          rpm_nxt        = quo_r;
          out_valid_nxt  = 1'b1;
          out_pos_nxt    = '0;
          out_rpm_nxt    = quo_r;
          out_sample_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rpm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rpm_r       <= rpm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r        <= mag_nxt;
    el_r         <= el_nxt;
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    bit_r        <= bit_nxt;
    out_pos_r    <= out_pos_nxt;
    out_rpm_r    <= out_rpm_nxt;
    out_sample_r <= out_sample_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_position_count = out_pos_r;
  assign out_speed_rpm      = out_rpm_r;
  assign out_sample_taken   = out_sample_r;

endmodule

`default_nettype wire

// ----- src/quadrature_decoder_rpm_meter.sv -----
// top level: 4x quadrature decoder with periodic rpm sampling
// count or clear items: queued, then moved to the output register when the back end is free
// a sample tick goes through the back end as multiply, range check and restoring
// division in the one-bit-per-cycle divider, then waits until the output is free
// throughput: 1 item per cycle while the 4-entry queue has room
// reset: synchronous active-low rst_n clears count, elapsed, rpm, queue and fsm
`default_nettype none

module quadrature_decoder_rpm_meter
  import qdrpm_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // item input
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_kind,
  input  wire logic                 in_level_a,
  input  wire logic                 in_level_b,
  // results
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [POS_W-1:0]   out_position_count,
  output logic [15:0]               out_speed_rpm,
  output logic                      out_sample_taken,
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  logic [15:0] cpr_r, cpr_nxt;
  logic [15:0] interval_r, interval_nxt;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;
  entry_t      wr_entry;
  entry_t      head;

  // registers are always writable; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cpr_nxt      = cpr_r;
    interval_nxt = interval_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COUNTS_PER_REV:  cpr_nxt = cfg_data;
        CFG_SAMPLE_INTERVAL: interval_nxt = cfg_data;
        default: begin
          cpr_nxt = cpr_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r      <= CPR_RESET;
      interval_r <= INTERVAL_RESET;
    end else begin
      cpr_r      <= cpr_nxt;
      interval_r <= interval_nxt;
    end
  end

  // front stalls only when the queue is full
  assign in_stall = q_full;
  assign push     = in_valid && !in_stall;

  // front end: counting and sample-window decisions, one item per cycle while the queue has room
  qdrpm_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .kind               (in_kind),
    .level_a            (in_level_a),
    .level_b            (in_level_b),
    .sample_interval_ms (interval_r),
    .entry              (wr_entry)
  );

  // queue decouples counting from the slow division
  qdrpm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back end: rpm division and in-order result delivery
  qdrpm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .empty              (q_empty),
    .head               (head),
    .pop                (pop),
    .counts_per_rev     (cpr_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_position_count (out_position_count),
    .out_speed_rpm      (out_speed_rpm),
    .out_sample_taken   (out_sample_taken)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_quadrature_decoder_rpm_meter.sv -----
// self-checking testbench for the quadrature decoder and rpm meter top level
`default_nettype none

module tb_quadrature_decoder_rpm_meter
  import qdrpm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // the full 32-bit count, as the speed meter is specified
  localparam int TB_COUNT_W = 32;

  // register indexes beyond the two real registers, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // cycles with no handshake at all before the run is declared hung
  localparam int HANG_LIMIT = 2000;
  // quiet cycles after the last result, well past the divider latency
  localparam int TAIL_CYCLES = 40;

  // one result item as the block should present it
  typedef struct {
    logic signed [POS_W-1:0] pos;
    logic [15:0]             rpm;
    logic                    taken;
  } reading_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             in_kind = KIND_TICK;
  logic                   in_level_a = 1'b0;
  logic                   in_level_b = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [POS_W-1:0] out_position_count;
  logic [15:0]            out_speed_rpm;
  logic                   out_sample_taken;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_COUNTS_PER_REV;
  logic [15:0]            cfg_data = 16'd0;

  // expected readings in arrival order, oldest at the front
  reading_t pending_readings[$];

  // local copy of the meter: count, window, last speed and both registers
  longint model_count = 0;
  int     model_elapsed = 0;
  int     model_rpm = 0;
  int     model_cpr = int'(CPR_RESET);
  int     model_interval = int'(INTERVAL_RESET);

  // levels of the emulated encoder shaft
  logic enc_a = 1'b0;
  logic enc_b = 1'b0;

  // when set, that side never idles (used for stretches at full rate)
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  int error_count = 0;
  int items_sent = 0;
  int readings_seen = 0;
  int samples_seen = 0;
  int reg_writes = 0;
  int hang_count = 0;
  int rx_hold = 0;

  quadrature_decoder_rpm_meter #(
    .COUNT_WIDTH(TB_COUNT_W)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_level_a        (in_level_a),
    .in_level_b        (in_level_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_position_count(out_position_count),
    .out_speed_rpm     (out_speed_rpm),
    .out_sample_taken  (out_sample_taken),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void note_error(string what);
    error_count++;
    if (error_count <= 10) $display("%s", what);
  endfunction

  // one edge of the 4x count, held inside +/- the count limit
  function automatic void move_edge_count(bit up);
    longint lim;
    lim = (longint'(1) << (TB_COUNT_W - 1)) - 1;
    if (up) begin
      if (model_count < lim) model_count++;
    end else begin
      if (model_count > -lim) model_count--;
    end
  endfunction

  // advance the meter by one item and return the reading it produces
  function automatic reading_t advance_meter(kind_t k, logic a, logic b);
    reading_t r;
    longint   mag;
    longint   den;
    longint   quo;
    r.taken = 1'b0;
    case (k)
      KIND_TICK: begin
        // the ms counter sticks at its top, then the window test runs
        if (model_elapsed < int'(ELAPSED_MAX)) model_elapsed++;
        if (model_elapsed >= model_interval) begin
          mag = (model_count < 0) ? -model_count : model_count;
          // a zero counts per rev divides as one
          den = longint'((model_cpr == 0) ? 1 : model_cpr) * longint'(model_elapsed);
          quo = (mag * longint'(MS_PER_MINUTE)) / den;
          model_rpm = (quo > longint'(RPM_MAX)) ? int'(RPM_MAX) : int'(quo);
          model_count = 0;
          model_elapsed = 0;
          r.taken = 1'b1;
        end
      end
      // a on its own edge: down when the levels match, up otherwise
      KIND_PHASE_A: move_edge_count(a != b);
      // b on its own edge: the other way round
      KIND_PHASE_B: move_edge_count(a == b);
      // clear touches the count only, the window keeps running
      default: model_count = 0;
    endcase
    r.pos = model_count[POS_W-1:0];
    r.rpm = model_rpm[15:0];
    return r;
  endfunction

  // mostly back to back, some short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // offer one item after a random gap, hold it until taken, then predict
  task automatic send_item(kind_t k, logic a, logic b);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= k;
    in_level_a <= a;
    in_level_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_readings.push_back(advance_meter(k, a, b));
    enc_a = a;
    enc_b = b;
    items_sent++;
  endtask

  // one legal encoder step; forward always counts up, reverse always down
  task automatic quad_step(bit fwd);
    if (fwd == (enc_a == enc_b)) send_item(KIND_PHASE_A, ~enc_a, enc_b);
    else send_item(KIND_PHASE_B, enc_a, ~enc_b);
  endtask

  // sender holds off until every expected reading is back
  task automatic settle_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // register write; only called with the block drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_COUNTS_PER_REV) model_cpr = int'(val);
    else if (idx == CFG_SAMPLE_INTERVAL) model_interval = int'(val);
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // direction truth table for both phases, inconsistent levels, clear, tick
  task automatic test_direction_rule();
    send_item(KIND_PHASE_A, 1'b1, 1'b0);
    send_item(KIND_PHASE_B, 1'b1, 1'b1);
    send_item(KIND_PHASE_A, 1'b0, 1'b1);
    send_item(KIND_PHASE_B, 1'b0, 1'b0);
    send_item(KIND_PHASE_B, 1'b0, 1'b1);
    send_item(KIND_PHASE_A, 1'b1, 1'b1);
    send_item(KIND_PHASE_B, 1'b1, 1'b0);
    send_item(KIND_PHASE_A, 1'b0, 1'b0);
    // levels that a real encoder would not give
    send_item(KIND_PHASE_A, 1'b0, 1'b0);
    send_item(KIND_PHASE_B, 1'b1, 1'b1);
    send_item(KIND_CLEAR, 1'b1, 1'b1);
    send_item(KIND_TICK, 1'b1, 1'b1);
    settle_all();
  endtask

  // register extremes, zero registers, dropped indexes and a lowered window
  task automatic test_sample_extremes();
    write_reg(CFG_COUNTS_PER_REV, 16'd1);
    write_reg(CFG_SAMPLE_INTERVAL, 16'd1);
    repeat (4) quad_step(1'b1);
    send_item(KIND_TICK, enc_a, enc_b);   // rpm clips at the top
    send_item(KIND_TICK, enc_a, enc_b);   // empty window gives zero
    settle_all();
    // zero counts per rev acts as one, zero interval samples every tick
    write_reg(CFG_COUNTS_PER_REV, 16'd0);
    write_reg(CFG_SAMPLE_INTERVAL, 16'd0);
    repeat (2) quad_step(1'b0);
    send_item(KIND_TICK, enc_a, enc_b);
    settle_all();
    write_reg(CFG_COUNTS_PER_REV, 16'hFFFF);
    write_reg(CFG_SAMPLE_INTERVAL, 16'd2);
    // indexes past the register list must leave both registers alone
    write_reg(CFG_SPARE_2, 16'hFFFF);
    write_reg(CFG_SPARE_3, 16'h0000);
    repeat (3) quad_step(1'b1);
    send_item(KIND_TICK, enc_a, enc_b);
    send_item(KIND_TICK, enc_a, enc_b);
    settle_all();
    // interval lowered below the elapsed count: next tick closes the window
    write_reg(CFG_SAMPLE_INTERVAL, 16'hFFFF);
    repeat (5) send_item(KIND_TICK, enc_a, enc_b);
    settle_all();
    write_reg(CFG_SAMPLE_INTERVAL, 16'd3);
    send_item(KIND_TICK, enc_a, enc_b);
    settle_all();
  endtask

  // a long run forward, a longer one back through zero, then a clear
  task automatic test_long_runs();
    write_reg(CFG_SAMPLE_INTERVAL, 16'hFFFF);
    repeat (60) quad_step(1'b1);
    repeat (120) quad_step(1'b0);
    send_item(KIND_CLEAR, enc_a, enc_b);
    settle_all();
  endtask

  // phases of register settings, extremes first then random, each a stream
  // of mostly legal encoder motion with ticks, clears and junk items mixed in
  task automatic test_random_motion();
    int  phase;
    int  n;
    int  r;
    int  tick_pct;
    bit  fwd;
    logic [15:0] cpr_val;
    logic [15:0] ivl_val;
    for (phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin cpr_val = 16'd1;    ivl_val = 16'd1;    end
        1: begin cpr_val = 16'hFFFF; ivl_val = 16'hFFFF; end
        2: begin cpr_val = 16'd0;    ivl_val = 16'd0;    end
        default: begin
          case ($urandom_range(0, 5))
            0: cpr_val = 16'd0;
            1: cpr_val = 16'd1;
            2: cpr_val = 16'hFFFF;
            3: cpr_val = 16'($urandom_range(1, 8));
            4: cpr_val = 16'($urandom_range(9, 4096));
            default: cpr_val = 16'($urandom);
          endcase
          case ($urandom_range(0, 5))
            0: ivl_val = 16'd0;
            1: ivl_val = 16'd1;
            2: ivl_val = 16'($urandom_range(2, 6));
            3: ivl_val = 16'($urandom_range(7, 40));
            4: ivl_val = 16'hFFFF;
            default: ivl_val = 16'($urandom);
          endcase
        end
      endcase
      write_reg(CFG_COUNTS_PER_REV, cpr_val);
      write_reg(CFG_SAMPLE_INTERVAL, ivl_val);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_2 | CFG_IDX_W'($urandom_range(0, 1)),
                                               16'($urandom));
      // some phases at full rate on one side or both
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: tick_pct = 0;
        1: tick_pct = 2;
        2: tick_pct = 8;
        default: tick_pct = 30;
      endcase
      fwd = 1'($urandom_range(0, 1));
      for (n = 0; n < 120; n++) begin
        r = $urandom_range(0, 99);
        if (r < tick_pct) begin
          send_item(KIND_TICK, enc_a, enc_b);
        end else if (r < tick_pct + 2) begin
          send_item(KIND_CLEAR, enc_a, enc_b);
        end else if (r < tick_pct + 14) begin
          send_item(kind_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
        end else begin
          if ($urandom_range(0, 39) == 0) fwd = ~fwd;
          quad_step(fwd);
        end
      end
      settle_all();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // result side: compare each taken reading with the oldest prediction,
  // then decide the stall for the next cycle
  always @(posedge clk) begin : rx_side
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      readings_seen++;
      if (out_sample_taken) samples_seen++;
      if (pending_readings.size() == 0) begin
        note_error($sformatf("unexpected reading: pos %0d rpm %0d taken %0b",
                             out_position_count, out_speed_rpm, out_sample_taken));
      end else begin
        want = pending_readings.pop_front();
        if (out_position_count !== want.pos || out_speed_rpm !== want.rpm ||
            out_sample_taken !== want.taken) begin
          note_error($sformatf(
            "reading %0d: pos %0d/%0d rpm %0d/%0d taken %0b/%0b (expected/actual)",
            readings_seen, want.pos, out_position_count, want.rpm, out_speed_rpm,
            want.taken, out_sample_taken));
        end
      end
    end
    // stalls: started at random, now and then a long one
    if (rx_quiet) begin
      rx_hold = 0;
      out_stall <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      rx_hold = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // hang detector: any handshake on any channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      hang_count = 0;
    else
      hang_count++;
    if (hang_count >= HANG_LIMIT) begin
      $display("no handshake for %0d cycles, %0d readings outstanding",
               HANG_LIMIT, pending_readings.size());
      $display("tb_quadrature_decoder_rpm_meter: done, errors");
      $finish;
    end
  end

  initial begin
    // synchronous reset held low from time zero, then released once
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_direction_rule();
    test_sample_extremes();
    test_long_runs();
    test_random_motion();

    settle_all();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_readings.size() != 0)
      note_error($sformatf("%0d readings never arrived", pending_readings.size()));

    $display("ran %0d items through %0d register writes; %0d readings, %0d speed samples",
             items_sent, reg_writes, readings_seen, samples_seen);
    $display("covered direction table, long runs both ways, zero and extreme registers");
    if (error_count == 0) begin
      $display("tb_quadrature_decoder_rpm_meter: done, clean");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("tb_quadrature_decoder_rpm_meter: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/qdrpm_pkg.sv
src/qdrpm_front.sv
src/qdrpm_fifo.sv
src/qdrpm_back.sv
src/quadrature_decoder_rpm_meter.sv
tb/sv/tb_quadrature_decoder_rpm_meter.sv
